// ===== src/binomial_coefficient_mod_prime_core_macros.svh =====
// assertion helpers for the rtl core, clocked on i_clk, quiet during reset
`ifndef BINOMIAL_COEFFICIENT_MOD_PRIME_CORE_MACROS_SVH
`define BINOMIAL_COEFFICIENT_MOD_PRIME_CORE_MACROS_SVH

// same-cycle implication
`define BCMP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BCMP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bcmp_pkg.sv =====
package bcmp_pkg;

    localparam int VW = 30;
    localparam logic [VW-1:0] MOD_P      = 30'd1000000007;
    localparam logic [VW-1:0] FERMAT_EXP = 30'd1000000005;

    localparam logic [1:0] OP_BUILD = 2'd0;
    localparam logic [1:0] OP_BINOM = 2'd1;
    localparam logic [1:0] OP_INV   = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BEYOND  = 2'd1;
    localparam logic [1:0] ST_UNBUILT = 2'd2;

    // one multiplier bit per step, msb first
    localparam logic [4:0] MUL_LAST = 5'd29;

    typedef struct packed {
        logic          start;
        logic [VW-1:0] a;
        logic [VW-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic          busy;
        logic          done;
        logic [VW-1:0] result;
    } t_mul_rsp;

endpackage

// ===== src/bcmp_mulmod.sv =====
module bcmp_mulmod import bcmp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [4:0]    r_cnt, n_cnt;
    logic [VW-1:0] r_acc, n_acc;
    logic [VW-1:0] r_a, n_a;
    logic [VW-1:0] r_b, n_b;
    logic [VW:0]   dbl, dbl_r, sum, sum_r;

    // horner step: acc = 2*acc + bit*a, each add folded back below p
    always_comb begin
        dbl   = {r_acc, 1'b0};
        dbl_r = (dbl >= {1'b0, MOD_P}) ? dbl - {1'b0, MOD_P} : dbl;
        sum   = dbl_r + {1'b0, (r_b[VW-1] ? r_a : {VW{1'b0}})};
        sum_r = (sum >= {1'b0, MOD_P}) ? sum - {1'b0, MOD_P} : sum;

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd0;
            n_acc  = {VW{1'b0}};
            n_a    = i_req.a;
            n_b    = i_req.b;
        end else if (r_busy) begin
            n_acc = sum_r[VW-1:0];
            n_b   = {r_b[VW-2:0], 1'b0};
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == MUL_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_acc;

endmodule

// ===== src/binomial_coefficient_mod_prime_core.sv =====
// channel   | handshake                  | payload
// ----------+----------------------------+----------------------------
// in item   | i_in_valid / o_in_ready    | i_op, i_n, i_k
// out item  | o_out_valid / i_out_ready  | o_value, o_status
// config    | i_cfg_we (no wait)         | i_cfg_data (table_bound)
//
// modular multiplies all run in the one shared shift-add unit
// query: two multiplies plus table reads; an inverse query only reads a table
// build with bound b: three multiplies per index plus 45 for the fermat power,
// all through the one multiply unit
// reset is synchronous, active low; tables are not cleared, only the built flag
// a result waiting in the output register stalls only the finish of the next item
`include "binomial_coefficient_mod_prime_core_macros.svh"

module binomial_coefficient_mod_prime_core import bcmp_pkg::*; #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_op,
    input  logic signed [12:0] i_n,
    input  logic signed [12:0] i_k,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [VW-1:0]      o_value,
    output logic [1:0]         o_status,
    input  logic               i_cfg_we,
    input  logic [11:0]        i_cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int BW = (AW > 12) ? AW : 12;
    localparam int QW = (AW > 13) ? AW : 13;

    // sequencer codes
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_DISP = 5'd1;
    localparam logic [4:0] S_QRD1 = 5'd2;
    localparam logic [4:0] S_QRD2 = 5'd3;
    localparam logic [4:0] S_QW1  = 5'd4;
    localparam logic [4:0] S_QW2  = 5'd5;
    localparam logic [4:0] S_IRD1 = 5'd6;
    localparam logic [4:0] S_IRD2 = 5'd7;
    localparam logic [4:0] S_BF   = 5'd8;
    localparam logic [4:0] S_BFW  = 5'd9;
    localparam logic [4:0] S_PM   = 5'd10;
    localparam logic [4:0] S_PMW  = 5'd11;
    localparam logic [4:0] S_PS   = 5'd12;
    localparam logic [4:0] S_PSW  = 5'd13;
    localparam logic [4:0] S_PEND = 5'd14;
    localparam logic [4:0] S_DRD  = 5'd15;
    localparam logic [4:0] S_DM1  = 5'd16;
    localparam logic [4:0] S_DW1  = 5'd17;
    localparam logic [4:0] S_DW2  = 5'd18;
    localparam logic [4:0] S_BEND = 5'd19;
    localparam logic [4:0] S_DONE = 5'd20;

    logic [4:0]         r_state, n_state;
    logic [1:0]         r_op, n_op;
    logic signed [12:0] r_n, n_n;
    logic signed [12:0] r_k, n_k;
    logic [AW-1:0]      r_i, n_i;
    logic [AW-1:0]      r_top, n_top;
    logic [VW-1:0]      r_acc, n_acc;    // running product, also power base
    logic [VW-1:0]      r_pacc, n_pacc;  // power accumulator
    logic [VW-1:0]      r_exp, n_exp;
    logic [AW-1:0]      r_fa, n_fa;
    logic [AW-1:0]      r_ia, n_ia;
    logic [AW-1:0]      r_va, n_va;
    logic               r_built, n_built;
    logic [AW-1:0]      r_bound, n_bound;
    logic [11:0]        r_cfg_bound;
    logic [VW-1:0]      r_res_val, n_res_val;
    logic [1:0]         r_res_st, n_res_st;
    logic               r_out_valid, n_out_valid;
    logic [VW-1:0]      r_out_value, n_out_value;
    logic [1:0]         r_out_status, n_out_status;

    // table storage, written only by a build
    logic [VW-1:0] fact_mem [TABLE_DEPTH];
    logic [VW-1:0] ifact_mem [TABLE_DEPTH];
    logic [VW-1:0] inv_mem [TABLE_DEPTH];
    logic [VW-1:0] r_f_rd, r_if_rd, r_inv_rd;

    logic          f_we, if_we, inv_we;
    logic [AW-1:0] f_wa, if_wa, inv_wa;
    logic [VW-1:0] f_wd, if_wd, inv_wd;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    logic [BW-1:0] bound_ext;
    logic [AW-1:0] top_sat;
    logic          n_neg, k_neg, n_lt_k, n_beyond;
    logic [VW-1:0] exp_shr;
    logic          mul_wait, out_err;

    bcmp_mulmod u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_status    = r_out_status;

    always_comb begin
        // bound saturates at the last table entry
        bound_ext = BW'(r_cfg_bound);
        top_sat   = (bound_ext > BW'(TABLE_DEPTH - 1)) ? AW'(TABLE_DEPTH - 1)
                                                       : AW'(bound_ext);
        n_neg    = r_n[12];
        k_neg    = r_k[12];
        n_lt_k   = (r_n < r_k);
        n_beyond = (QW'(r_n[11:0]) > QW'(r_bound));
        exp_shr  = {1'b0, r_exp[VW-1:1]};

        n_state   = r_state;
        n_op      = r_op;
        n_n       = r_n;
        n_k       = r_k;
        n_i       = r_i;
        n_top     = r_top;
        n_acc     = r_acc;
        n_pacc    = r_pacc;
        n_exp     = r_exp;
        n_fa      = r_fa;
        n_ia      = r_ia;
        n_va      = r_va;
        n_built   = r_built;
        n_bound   = r_bound;
        n_res_val = r_res_val;
        n_res_st  = r_res_st;

        f_we   = 1'b0;
        f_wa   = r_i;
        f_wd   = mul_rsp.result;
        if_we  = 1'b0;
        if_wa  = r_i;
        if_wd  = mul_rsp.result;
        inv_we = 1'b0;
        inv_wa = r_i;
        inv_wd = mul_rsp.result;

        mul_req.start = 1'b0;
        mul_req.a     = r_acc;
        mul_req.b     = r_acc;

        // output register drains independently of the sequencer
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_op;
                    n_n     = i_n;
                    n_k     = i_k;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_res_val = {VW{1'b0}};
                n_res_st  = ST_OK;
                case (r_op)
                    OP_BUILD: begin
                        f_we    = 1'b1;
                        f_wa    = {AW{1'b0}};
                        f_wd    = VW'(1);
                        n_top   = top_sat;
                        n_acc   = VW'(1);
                        n_i     = AW'(1);
                        n_pacc  = VW'(1);
                        n_exp   = FERMAT_EXP;
                        n_state = (top_sat == {AW{1'b0}}) ? S_PM : S_BF;
                    end
                    OP_BINOM: begin
                        if (!r_built) begin
                            n_res_st = ST_UNBUILT;
                            n_state  = S_DONE;
                        end else if (n_lt_k || n_neg || k_neg) begin
                            n_state = S_DONE;
                        end else if (n_beyond) begin
                            n_res_st = ST_BEYOND;
                            n_state  = S_DONE;
                        end else begin
                            n_fa    = AW'(r_n[11:0]);
                            n_ia    = AW'(r_n[11:0] - r_k[11:0]);
                            n_state = S_QRD1;
                        end
                    end
                    OP_INV: begin
                        if (!r_built) begin
                            n_res_st = ST_UNBUILT;
                            n_state  = S_DONE;
                        end else if (n_neg || n_beyond) begin
                            n_res_st = ST_BEYOND;
                            n_state  = S_DONE;
                        end else begin
                            n_va    = AW'(r_n[11:0]);
                            n_state = S_IRD1;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_QRD1: begin
                n_state = S_QRD2;
            end
            S_QRD2: begin
                // n! * inv((n-k)!), then fetch inv(k!) meanwhile
                mul_req.start = 1'b1;
                mul_req.a     = r_f_rd;
                mul_req.b     = r_if_rd;
                n_ia          = AW'(r_k[11:0]);
                n_state       = S_QW1;
            end
            S_QW1: begin
                if (mul_rsp.done) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = mul_rsp.result;
                    mul_req.b     = r_if_rd;
                    n_state       = S_QW2;
                end
            end
            S_QW2: begin
                if (mul_rsp.done) begin
                    n_res_val = mul_rsp.result;
                    n_state   = S_DONE;
                end
            end
            S_IRD1: begin
                n_state = S_IRD2;
            end
            S_IRD2: begin
                n_res_val = r_inv_rd;
                n_state   = S_DONE;
            end
            S_BF: begin
                // i! = (i-1)! * i
                mul_req.start = 1'b1;
                mul_req.a     = r_acc;
                mul_req.b     = VW'(r_i);
                n_state       = S_BFW;
            end
            S_BFW: begin
                if (mul_rsp.done) begin
                    f_we  = 1'b1;
                    n_acc = mul_rsp.result;
                    if (r_i == r_top) begin
                        n_pacc  = VW'(1);
                        n_exp   = FERMAT_EXP;
                        n_state = S_PM;
                    end else begin
                        n_i     = r_i + AW'(1);
                        n_state = S_BF;
                    end
                end
            end
            S_PM: begin
                // square and multiply, exponent lsb first
                if (r_exp[0]) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = r_pacc;
                    mul_req.b     = r_acc;
                    n_state       = S_PMW;
                end else begin
                    n_state = S_PS;
                end
            end
            S_PMW: begin
                if (mul_rsp.done) begin
                    n_pacc  = mul_rsp.result;
                    n_state = S_PS;
                end
            end
            S_PS: begin
                mul_req.start = 1'b1;
                mul_req.a     = r_acc;
                mul_req.b     = r_acc;
                n_state       = S_PSW;
            end
            S_PSW: begin
                if (mul_rsp.done) begin
                    n_acc   = mul_rsp.result;
                    n_exp   = exp_shr;
                    n_state = (exp_shr == {VW{1'b0}}) ? S_PEND : S_PM;
                end
            end
            S_PEND: begin
                if_we  = 1'b1;
                if_wa  = r_top;
                if_wd  = r_pacc;
                n_acc  = r_pacc;
                n_i    = r_top;
                if (r_top == {AW{1'b0}}) begin
                    n_state = S_BEND;
                end else begin
                    n_fa    = r_top - AW'(1);
                    n_state = S_DRD;
                end
            end
            S_DRD: begin
                n_state = S_DM1;
            end
            S_DM1: begin
                // inv(i) = (i-1)! * inv(i!)
                mul_req.start = 1'b1;
                mul_req.a     = r_f_rd;
                mul_req.b     = r_acc;
                n_state       = S_DW1;
            end
            S_DW1: begin
                if (mul_rsp.done) begin
                    inv_we        = 1'b1;
                    mul_req.start = 1'b1;
                    mul_req.a     = r_acc;
                    mul_req.b     = VW'(r_i);
                    n_state       = S_DW2;
                end
            end
            S_DW2: begin
                // inv((i-1)!) = inv(i!) * i
                if (mul_rsp.done) begin
                    if_we = 1'b1;
                    if_wa = r_i - AW'(1);
                    n_acc = mul_rsp.result;
                    if (r_i == AW'(1)) begin
                        n_state = S_BEND;
                    end else begin
                        n_i     = r_i - AW'(1);
                        n_fa    = r_i - AW'(2);
                        n_state = S_DRD;
                    end
                end
            end
            S_BEND: begin
                inv_we  = 1'b1;
                inv_wa  = {AW{1'b0}};
                inv_wd  = {VW{1'b0}};
                n_built = 1'b1;
                n_bound = r_top;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_res_val;
                    n_out_status = r_res_st;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_built     <= 1'b0;
            r_bound     <= {AW{1'b0}};
            r_cfg_bound <= 12'd4095;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_built     <= n_built;
            r_bound     <= n_bound;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cfg_bound <= i_cfg_data;
            end
        end
        r_op         <= n_op;
        r_n          <= n_n;
        r_k          <= n_k;
        r_i          <= n_i;
        r_top        <= n_top;
        r_acc        <= n_acc;
        r_pacc       <= n_pacc;
        r_exp        <= n_exp;
        r_fa         <= n_fa;
        r_ia         <= n_ia;
        r_va         <= n_va;
        r_res_val    <= n_res_val;
        r_res_st     <= n_res_st;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    always_ff @(posedge i_clk) begin
        if (f_we) begin
            fact_mem[f_wa] <= f_wd;
        end
        r_f_rd <= fact_mem[r_fa];
    end

    always_ff @(posedge i_clk) begin
        if (if_we) begin
            ifact_mem[if_wa] <= if_wd;
        end
        r_if_rd <= ifact_mem[r_ia];
    end

    always_ff @(posedge i_clk) begin
        if (inv_we) begin
            inv_mem[inv_wa] <= inv_wd;
        end
        r_inv_rd <= inv_mem[r_va];
    end

    // states that wait on a product
    assign mul_wait = (r_state == S_QW1) || (r_state == S_QW2) || (r_state == S_BFW)
                   || (r_state == S_PMW) || (r_state == S_PSW) || (r_state == S_DW1)
                   || (r_state == S_DW2);
    assign out_err  = r_out_valid && (r_out_status != ST_OK);

    `BCMP_ASSERT_NOW(a_out_reduced, r_out_valid, r_out_value < MOD_P, "result not reduced")
    `BCMP_ASSERT_NOW(a_err_zero, out_err, r_out_value == '0, "error with value")
    `BCMP_ASSERT_NOW(a_idle_mul, r_state == S_IDLE, !mul_rsp.busy, "multiplier busy while idle")
    `BCMP_ASSERT_NOW(a_done_waited, mul_rsp.done, mul_wait, "unexpected product")
    `BCMP_ASSERT_NEXT(a_build_done, r_state == S_BEND, r_built, "build did not mark tables")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb import bcmp_pkg::*;;

    // op code 3 is unused by the block, it must answer zero with status ok
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam longint PRIME = 64'd1000000007;
    localparam int DEPTH = 4096;
    localparam int IDLE_PCT = 11;
    localparam int HOLD_CYCLES = 300;
    // the limit must outlast a build at the top bound, during which nothing moves
    localparam int STALL_LIMIT = 1500000;
    localparam int TAIL_CYCLES = 100;

    typedef struct {
        logic [VW-1:0] val;
        logic [1:0]    st;
    } t_result;

    typedef struct {
        logic [1:0]    op;
        int            n;
        int            k;
        bit            typed;
        logic [VW-1:0] val;
        logic [1:0]    st;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_op;
    logic signed [12:0] i_n;
    logic signed [12:0] i_k;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [VW-1:0]      o_value;
    logic [1:0]         o_status;
    logic               i_cfg_we;
    logic [11:0]        i_cfg_data;

    binomial_coefficient_mod_prime_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_n         (i_n),
        .i_k         (i_k),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value     (o_value),
        .o_status    (o_status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    // clock, 10 ns period
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // local copy of the tables and the build state
    longint   fact_tab [DEPTH];
    longint   ifact_tab [DEPTH];
    longint   inv_tab [DEPTH];
    bit       tabs_built;
    int       built_top;
    int       bound_reg;

    t_result  pending_results [$];
    int       fail_count;
    int       items_sent;
    int       results_seen;
    int       builds_sent;
    bit       calm;
    bit       hold_req;
    bit       hold_done;
    int       hold_cnt;
    int       stall_cnt;

    function automatic longint mulmod(longint a, longint b);
        return (a * b) % PRIME;
    endfunction

    function automatic longint powmod(longint b, longint e);
        longint acc;
        acc = 1;
        while (e != 0) begin
            if (e[0]) acc = mulmod(acc, b);
            b = mulmod(b, b);
            e = e >> 1;
        end
        return acc;
    endfunction

    // fill the local tables the way the block does: factorials up, one
    // fermat power for the top, inverse factorials down, inverses from both
    function automatic void fill_tables();
        int top;
        top = bound_reg;
        if (top > DEPTH - 1) top = DEPTH - 1;
        fact_tab[0] = 1;
        for (int i = 1; i <= top; i++) fact_tab[i] = mulmod(fact_tab[i-1], i);
        ifact_tab[top] = powmod(fact_tab[top], PRIME - 2);
        for (int i = top; i > 0; i--) ifact_tab[i-1] = mulmod(ifact_tab[i], i);
        inv_tab[0] = 0;
        for (int i = 1; i <= top; i++) inv_tab[i] = mulmod(fact_tab[i-1], ifact_tab[i]);
        built_top = top;
        tabs_built = 1'b1;
    endfunction

    function automatic t_result predict_binom(logic [1:0] op, int n, int k);
        t_result r;
        r.val = '0;
        r.st = ST_OK;
        if (op == OP_BUILD) begin
            fill_tables();
        end else if (op == OP_BINOM || op == OP_INV) begin
            if (!tabs_built) begin
                r.st = ST_UNBUILT;
            end else if (op == OP_BINOM) begin
                // out-of-order indices give zero before the bound is looked at
                if (n < k || n < 0 || k < 0) r.val = '0;
                else if (n > built_top) r.st = ST_BEYOND;
                else r.val = VW'(mulmod(mulmod(fact_tab[n], ifact_tab[n-k]), ifact_tab[k]));
            end else begin
                if (n < 0 || n > built_top) r.st = ST_BEYOND;
                else r.val = VW'(inv_tab[n]);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // send one item, predict when it is accepted; the typed row value wins
    task automatic send_item(t_row row);
        t_result r;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= row.op;
        i_n <= row.n[12:0];
        i_k <= row.k[12:0];
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        r = predict_binom(row.op, row.n, row.k);
        if (row.typed) begin
            r.val = row.val;
            r.st = row.st;
        end
        pending_results.push_back(r);
        items_sent++;
        if (row.op == OP_BUILD) builds_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_bound(int b);
        i_cfg_we <= 1'b1;
        i_cfg_data <= b[11:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        bound_reg = b;
    endtask

    function automatic t_row mk(logic [1:0] op, int n, int k);
        t_row row;
        row.op = op;
        row.n = n;
        row.k = k;
        row.typed = 1'b0;
        row.val = '0;
        row.st = ST_OK;
        return row;
    endfunction

    function automatic t_row mkx(logic [1:0] op, int n, int k, int v, logic [1:0] st);
        t_row row;
        row = mk(op, n, k);
        row.typed = 1'b1;
        row.val = VW'(v);
        row.st = st;
        return row;
    endfunction

    function automatic int rnd13();
        logic signed [12:0] x;
        x = 13'($urandom);
        return int'(x);
    endfunction

    // random item for a table of the given size: mostly in range, some anywhere
    function automatic t_row rand_item(int b);
        int r;
        int n;
        int k;
        logic [1:0] op;
        r = $urandom_range(99);
        op = r < 3 ? OP_BUILD : r < 60 ? OP_BINOM : r < 95 ? OP_INV : OP_NONE;
        n = ($urandom_range(3) == 0) ? rnd13() : $urandom_range(b + 2);
        if ($urandom_range(3) == 0) k = rnd13();
        else k = $urandom_range(n >= 0 ? n + 1 : 3);
        return mk(op, n, k);
    endfunction

    // receiver: random stalls, plus one long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // result checker, oldest expectation first
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected item", o_value, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_value !== want.val) report_mismatch("value", o_value, want.val);
                if (o_status !== want.st) report_mismatch("status", o_status, want.st);
            end
        end
    end

    // watchdog on cycles in which nothing moves
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("timeout with %0d items outstanding", pending_results.size());
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    initial begin
        t_row steps [$];
        int phase_bounds [8];
        phase_bounds = '{1, 7, 30, 2, 200, 15, 60, 4};
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_op = OP_BUILD;
        i_n = '0;
        i_k = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        fail_count = 0;
        items_sent = 0;
        results_seen = 0;
        builds_sent = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        hold_cnt = 0;
        stall_cnt = 0;
        tabs_built = 1'b0;
        built_top = 0;
        bound_reg = 4095;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // queries before any build, and the unused op code
        steps.push_back(mkx(OP_BINOM, 3, 1, 0, ST_UNBUILT));
        steps.push_back(mkx(OP_INV, 1, 0, 0, ST_UNBUILT));
        steps.push_back(mkx(OP_NONE, -1, -1, 0, ST_OK));
        foreach (steps[i]) send_item(steps[i]);
        wait_idle();
        steps.delete();

        // a small bound of one
        write_bound(1);
        steps.push_back(mkx(OP_BUILD, 0, 0, 0, ST_OK));
        steps.push_back(mkx(OP_BINOM, 1, 0, 1, ST_OK));
        steps.push_back(mkx(OP_BINOM, 1, 1, 1, ST_OK));
        steps.push_back(mkx(OP_BINOM, 0, 0, 1, ST_OK));
        steps.push_back(mkx(OP_BINOM, 1, 2, 0, ST_OK));
        steps.push_back(mkx(OP_BINOM, -1, 0, 0, ST_OK));
        steps.push_back(mkx(OP_BINOM, 0, -1, 0, ST_OK));
        steps.push_back(mkx(OP_BINOM, -4096, -4096, 0, ST_OK));
        steps.push_back(mkx(OP_BINOM, 2, 0, 0, ST_BEYOND));
        steps.push_back(mkx(OP_BINOM, 4095, 4095, 0, ST_BEYOND));
        steps.push_back(mkx(OP_INV, 0, 0, 0, ST_OK));
        steps.push_back(mkx(OP_INV, 1, -4096, 1, ST_OK));
        steps.push_back(mkx(OP_INV, 2, 0, 0, ST_BEYOND));
        steps.push_back(mkx(OP_INV, -1, 0, 0, ST_BEYOND));
        steps.push_back(mkx(OP_INV, 4095, 4095, 0, ST_BEYOND));
        steps.push_back(mkx(OP_NONE, 4095, 4095, 0, ST_OK));
        foreach (steps[i]) send_item(steps[i]);
        wait_idle();
        steps.delete();

        // full table once, then its extremes
        write_bound(4095);
        steps.push_back(mkx(OP_BUILD, 0, 0, 0, ST_OK));
        steps.push_back(mkx(OP_BINOM, 4095, 4095, 1, ST_OK));
        steps.push_back(mkx(OP_BINOM, 4095, 0, 1, ST_OK));
        steps.push_back(mk(OP_BINOM, 4095, 2047));
        steps.push_back(mk(OP_BINOM, 4094, 1));
        steps.push_back(mk(OP_INV, 4095, 0));
        steps.push_back(mk(OP_INV, 2, 0));
        steps.push_back(mkx(OP_BINOM, 4095, -4096, 0, ST_OK));
        foreach (steps[i]) send_item(steps[i]);
        wait_idle();
        steps.delete();

        // random phases, each on a fresh bound and build
        foreach (phase_bounds[p]) begin
            calm = (p == 2);
            write_bound(phase_bounds[p]);
            send_item(mk(OP_BUILD, rnd13(), rnd13()));
            for (int i = 0; i < 62; i++) begin
                if (p == 5 && i == 10) hold_req = 1'b1;
                send_item(rand_item(phase_bounds[p]));
            end
            wait_idle();
        end
        calm = 1'b0;

        $display("sent %0d items (%0d builds) over %0d table bounds, checked %0d results",
                 items_sent, builds_sent, 10, results_seen);
        $display("covered unbuilt, beyond, negative and out-of-order indices, op 3 and stalls");
        if (fail_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
